>>> rtl/owdm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owdm_pkg: shared types and constants of the omni wheel drive mixer
// Holds the cosine table, field widths and the stage payload structs.
// ---------------------------------------------------------------------------
package owdm_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int SUM_W          = 22;   // Q10 wheel sum, signed
  localparam int MAG_W          = 10;   // integer wheel magnitude
  localparam int NUM_W          = 17;   // rescale numerator
  localparam int QBITS          = 7;    // rescale quotient bits
  localparam int MS_W           = 6;
  localparam int GAIN_W         = 11;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 4;

  localparam logic [7:0] BYTE_FREE   = 8'd110;
  localparam logic [7:0] MID_POINT   = 8'd50;
  localparam logic [7:0] GYRO_CENTRE = 8'd127;
  localparam logic [7:0] HIGH_OFFSET = 8'd128;
  localparam logic [MS_W-1:0]   SPEED_LIM_RST = 6'd20;
  localparam logic [GAIN_W-1:0] YAW_GAIN_RST  = 11'd410;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_LIM = CFG_IDX_W'(0),
    REG_YAW_GAIN  = CFG_IDX_W'(1)
  } reg_idx_e;

  // Quarter-wave cosine, Q8.
  localparam logic [8:0] COS_Q [65] = '{
    9'd256, 9'd256, 9'd256, 9'd255, 9'd255, 9'd254, 9'd253, 9'd252, 9'd251, 9'd250,
    9'd248, 9'd247, 9'd245, 9'd243, 9'd241, 9'd239, 9'd237, 9'd234, 9'd231, 9'd229,
    9'd226, 9'd223, 9'd220, 9'd216, 9'd213, 9'd209, 9'd206, 9'd202, 9'd198, 9'd194,
    9'd190, 9'd185, 9'd181, 9'd177, 9'd172, 9'd167, 9'd162, 9'd157, 9'd152, 9'd147,
    9'd142, 9'd137, 9'd132, 9'd126, 9'd121, 9'd115, 9'd109, 9'd104, 9'd98,  9'd92,
    9'd86,  9'd80,  9'd74,  9'd68,  9'd62,  9'd56,  9'd50,  9'd44,  9'd38,  9'd31,
    9'd25,  9'd19,  9'd13,  9'd6,   9'd0
  };

  // Full-wave cosine from an 8-bit angle.
  function automatic logic signed [9:0] cos_q8(input logic [7:0] a8);
    logic [6:0] ri;
    logic [8:0] v;
    logic       neg;
    ri  = a8[6] ? (7'd64 - {1'b0, a8[5:0]}) : {1'b0, a8[5:0]};
    v   = COS_Q[ri];
    neg = a8[7] ^ a8[6];
    return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  // Payload leaving the front end.
  typedef struct packed {
    logic                        free;
    logic [3:0][SUM_W-1:0]       sum;
    logic [3:0][MAG_W-1:0]       mag;
    logic [MAG_W-1:0]            peak;
  } mix_t;

  // Payload inside the rescale divider.
  typedef struct packed {
    logic                        free;
    logic                        scale;
    logic [3:0][SUM_W-1:0]       sum;
    logic [3:0][NUM_W-1:0]       rem;
    logic [3:0][QBITS-1:0]       quo;
    logic [MAG_W-1:0]            peak;
  } div_t;

  // Four finished wheel bytes.
  typedef struct packed {
    logic                        free;
    logic [3:0][7:0]             bytes;
  } wheel_t;

endpackage

>>> rtl/owdm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owdm_front: cosine, products, wheel sums and peak magnitude
// Four register stages; the whole chain advances when en_i is high.
// ---------------------------------------------------------------------------
module owdm_front #(
  parameter int ANGLE_BITS = owdm_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic                          free_i,
  input  logic [ANGLE_BITS-1:0]         heading_i,
  input  logic [7:0]                    speed_i,
  input  logic [7:0]                    gyro_i,
  input  logic [owdm_pkg::GAIN_W-1:0]   gain_i,
  output logic                          valid_o,
  output owdm_pkg::mix_t                mix_o
);
  import owdm_pkg::*;

  localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

  logic [3:0] v_q;

  // Stage 1 registers.
  logic              free1_q;
  logic signed [9:0] cosa_q, cosb_q;
  logic [7:0]        speed1_q;
  logic signed [8:0] gyro1_q;
  // Stage 2 registers.
  logic               free2_q;
  logic signed [18:0] pa_q, pb_q;
  logic signed [20:0] yaw_q;
  // Stage 3 and stage 4 registers.
  logic                  free3_q;
  logic [3:0][SUM_W-1:0] sum3_q;
  logic [3:0][MAG_W-1:0] mag3_q;
  mix_t                  mix_q;

  logic [ANGLE_BITS-1:0] ang_a, ang_b;
  logic [3:0][SUM_W-1:0] sum_d;
  logic [3:0][MAG_W-1:0] mag_d;
  logic [MAG_W-1:0]      pk01, pk23, peak_d;
  logic [SUM_W-1:0]      pa_x, pb_x, yaw_x;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  assign ang_a = heading_i - EIGHTH;
  assign ang_b = heading_i + EIGHTH;

  // Wheel sums in Q10 and their integer magnitudes.
  always_comb begin
    logic [SUM_W-1:0] m;
    pa_x  = {{(SUM_W-21){pa_q[18]}}, pa_q, 2'b00};
    pb_x  = {{(SUM_W-21){pb_q[18]}}, pb_q, 2'b00};
    yaw_x = {{(SUM_W-21){yaw_q[20]}}, yaw_q};
    sum_d[0] = pa_x + yaw_x;
    sum_d[1] = pb_x + yaw_x;
    sum_d[2] = pa_x - yaw_x;
    sum_d[3] = pb_x - yaw_x;
    for (int i = 0; i < 4; i++) begin
      m        = sum_d[i][SUM_W-1] ? (~sum_d[i] + 1'b1) : sum_d[i];
      mag_d[i] = m[MAG_W+9:10];
    end
  end

  // Peak over the four magnitudes.
  assign pk01   = (mag3_q[0] > mag3_q[1]) ? mag3_q[0] : mag3_q[1];
  assign pk23   = (mag3_q[2] > mag3_q[3]) ? mag3_q[2] : mag3_q[3];
  assign peak_d = (pk01 > pk23) ? pk01 : pk23;

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      free1_q  <= free_i;
      cosa_q   <= cos_q8(ang_a[ANGLE_BITS-1 -: 8]);
      cosb_q   <= cos_q8(ang_b[ANGLE_BITS-1 -: 8]);
      speed1_q <= speed_i;
      gyro1_q  <= $signed({1'b0, gyro_i}) - $signed({1'b0, GYRO_CENTRE});

      free2_q  <= free1_q;
      pa_q     <= $signed({1'b0, speed1_q}) * cosa_q;
      pb_q     <= $signed({1'b0, speed1_q}) * cosb_q;
      yaw_q    <= $signed({1'b0, gain_i}) * gyro1_q;

      free3_q  <= free2_q;
      sum3_q   <= sum_d;
      mag3_q   <= mag_d;

      mix_q.free <= free3_q;
      mix_q.sum  <= sum3_q;
      mix_q.mag  <= mag3_q;
      mix_q.peak <= peak_d;
    end
  end

  assign valid_o = v_q[3];
  assign mix_o   = mix_q;

endmodule

>>> rtl/owdm_scale.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owdm_scale: rescale numerator, bit-per-stage divider and byte mapping
// One stage forms the numerator, one stage per quotient bit, one stage
// builds the four wheel bytes.
// ---------------------------------------------------------------------------
module owdm_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  owdm_pkg::mix_t              mix_i,
  input  logic [owdm_pkg::MS_W-1:0]   speed_lim_i,
  output logic                        valid_o,
  output owdm_pkg::wheel_t            wheel_o
);
  import owdm_pkg::*;

  logic [QBITS+1:0] v_q;
  div_t             pipe_q [QBITS+1];
  div_t             pipe_d [QBITS+1];
  wheel_t           wheel_q, wheel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QBITS:0], valid_i};
    end
  end

  // Numerator (x + peak) * speed limit with x the signed integer magnitude.
  always_comb begin
    logic [MAG_W:0] xp;
    pipe_d[0].free  = mix_i.free;
    pipe_d[0].scale = mix_i.peak > {{(MAG_W-MS_W){1'b0}}, speed_lim_i};
    pipe_d[0].sum   = mix_i.sum;
    pipe_d[0].quo   = '0;
    pipe_d[0].peak  = mix_i.peak;
    for (int i = 0; i < 4; i++) begin
      xp = mix_i.sum[i][SUM_W-1] ? ({1'b0, mix_i.peak} - {1'b0, mix_i.mag[i]})
                                 : ({1'b0, mix_i.peak} + {1'b0, mix_i.mag[i]});
      pipe_d[0].rem[i] = NUM_W'(xp) * NUM_W'(speed_lim_i);
    end
  end

  // Restoring divider, one quotient bit per stage, MSB first.
  for (genvar j = 0; j < QBITS; j++) begin : g_div
    always_comb begin
      logic [NUM_W-1:0] dv;
      pipe_d[j+1] = pipe_q[j];
      dv = NUM_W'(pipe_q[j].peak) << (QBITS - 1 - j);
      for (int i = 0; i < 4; i++) begin
        if (pipe_q[j].rem[i] >= dv) begin
          pipe_d[j+1].rem[i]             = pipe_q[j].rem[i] - dv;
          pipe_d[j+1].quo[i][QBITS-1-j]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s <= QBITS; s++) begin
        pipe_q[s] <= pipe_d[s];
      end
      wheel_q <= wheel_d;
    end
  end

  // Wheel bytes: mapped band when scaling, plain offset otherwise.
  always_comb begin
    logic [SUM_W+1:0] t;
    logic [SUM_W+1:0] th;
    logic [7:0]       b;
    wheel_d.free = pipe_q[QBITS].free;
    for (int i = 0; i < 4; i++) begin
      t  = {{2{pipe_q[QBITS].sum[i][SUM_W-1]}}, pipe_q[QBITS].sum[i]}
           + (SUM_W+2)'(51200);
      th = t + (SUM_W+2)'(131072);
      if (pipe_q[QBITS].scale) begin
        b = {1'b0, pipe_q[QBITS].quo[i]} + MID_POINT - {2'b00, speed_lim_i};
        if (i % 2 == 1) begin
          b = b + HIGH_OFFSET;
        end
      end else begin
        if (i % 2 == 1) begin
          b = th[17:10];
        end else begin
          b = t[SUM_W+1] ? 8'd0 : t[17:10];
        end
      end
      wheel_d.bytes[i] = b;
    end
  end

  assign valid_o = v_q[QBITS+1];
  assign wheel_o = wheel_q;

endmodule

>>> rtl/owdm_ser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owdm_ser: output serializer
// Sends the wheel bytes of one request, two for a free request.
// ---------------------------------------------------------------------------
module owdm_ser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  owdm_pkg::wheel_t wheel_i,
  output logic             load_ok_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);
  import owdm_pkg::*;

  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  wheel_t     hold_q;
  logic       take, load;

  assign take      = m_axis_tvalid && m_axis_tready;
  assign load_ok_o = !busy_q || (take && m_axis_tlast);
  assign load      = load_ok_o && valid_i;

  // Byte counter and busy flag.
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (take) begin
      busy_d = !m_axis_tlast;
      idx_d  = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hold_q <= wheel_i;
    end
  end

  // Current byte, link and end-of-request mark.
  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = hold_q.free ? BYTE_FREE : hold_q.bytes[idx_q];
  assign m_axis_tuser  = hold_q.free ? idx_q[0] : idx_q[1];
  assign m_axis_tlast  = hold_q.free ? (idx_q == 2'd1) : (idx_q == 2'd3);

endmodule

>>> rtl/omni_wheel_drive_mixer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// omni_wheel_drive_mixer: four-wheel omni drive mixing
// Turns move and free requests into motor driver command bytes.
// ---------------------------------------------------------------------------
// A request enters every cycle the pipeline is not stalled; its bytes leave
// one per cycle while m_axis_tready is high, four for a move request and
// two for a free one, so the single-byte output channel sets the sustained
// rate. A request passes the front end (four stages) and the rescale divider
// (one stage per quotient bit plus numerator and byte stages). Configuration
// registers must only be written while no request is in flight.
module omni_wheel_drive_mixer #(
  parameter int ANGLE_BITS = owdm_pkg::ANGLE_BITS_DEF,
  localparam int TDATA_W   = ((ANGLE_BITS + 16 + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [owdm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [owdm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [TDATA_W-1:0]             s_axis_tdata,   // heading, speed, gyro
  input  logic                           s_axis_tuser,   // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // data_byte
  output logic                           m_axis_tuser,   // port
  output logic                           m_axis_tlast    // last
);
  import owdm_pkg::*;

  logic [MS_W-1:0]   speed_lim_q;
  logic [GAIN_W-1:0] gain_q;
  logic              en, load_ok;
  logic              fr_v, sc_v;
  mix_t              mix;
  wheel_t            wheel;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_lim_q <= SPEED_LIM_RST;
      gain_q      <= YAW_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SPEED_LIM: speed_lim_q <= cfg_data_i[MS_W-1:0];
        REG_YAW_GAIN:  gain_q      <= cfg_data_i[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // The whole pipeline advances unless its last stage is held.
  assign en            = !sc_v || load_ok;
  assign s_axis_tready = en;

  owdm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .free_i    (s_axis_tuser),
    .heading_i (s_axis_tdata[ANGLE_BITS-1:0]),
    .speed_i   (s_axis_tdata[ANGLE_BITS+7:ANGLE_BITS]),
    .gyro_i    (s_axis_tdata[ANGLE_BITS+15:ANGLE_BITS+8]),
    .gain_i    (gain_q),
    .valid_o   (fr_v),
    .mix_o     (mix)
  );

  owdm_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (fr_v),
    .mix_i       (mix),
    .speed_lim_i (speed_lim_q),
    .valid_o     (sc_v),
    .wheel_o     (wheel)
  );

  owdm_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (sc_v),
    .wheel_i       (wheel),
    .load_ok_o     (load_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A stall only happens while the serializer still holds bytes.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !(m_axis_tready && m_axis_tlast)))
    else $error("input stalled with serializer free");

  // Every request ends on link B.
  a_last_link_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("last byte not on link B");

  // A byte taken that is not the last is followed by another one.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("request cut short");

endmodule
